FILE: rtl/core/pbd_pkg.sv
`default_nettype none

package pbd_pkg;

	// Field widths fixed by the pixel and result formats.
	localparam int unsigned RGB_W   = 24;
	localparam int unsigned INDEX_W = 8;
	localparam int unsigned COUNT_W = 9;

	// One pixel request.
	typedef struct packed {
		logic [RGB_W-1:0] pixel_rgb;
		logic             last_pixel;
	} pixel_t;

	// One result request.
	typedef struct packed {
		logic [INDEX_W-1:0] palette_index;
		logic               new_color;
		logic               overflow;
		logic [COUNT_W-1:0] color_count;
		logic               end_of_image;
	} result_t;

	// Token handed from cell to cell along the chain. Index and count carry
	// only the bits that reach the result.
	typedef struct packed {
		logic               valid;
		logic [RGB_W-1:0]   rgb;
		logic               last;
		logic               found;
		logic               is_new;
		logic [INDEX_W-1:0] index;
		logic [COUNT_W-1:0] count;
	} token_t;

endpackage

`default_nettype wire

FILE: rtl/core/pbd_stream_if.sv
`default_nettype none

interface pbd_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

FILE: rtl/core/pbd_cell.sv
`default_nettype none

module pbd_cell #(
	parameter int unsigned CELL_INDEX = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            advance,
	input  wire pbd_pkg::token_t tok_in,
	output pbd_pkg::token_t      tok_out
);

	import pbd_pkg::*;

	localparam logic [INDEX_W-1:0] MY_INDEX = INDEX_W'(CELL_INDEX);
	localparam logic [COUNT_W-1:0] MY_COUNT = COUNT_W'(CELL_INDEX + 1);

	logic [RGB_W-1:0] color_q;
	logic             occupied_q;
	token_t           tok_q;
	token_t           tok_next;
	logic             hit;
	logic             ins;

	// Compare against the held colour, or claim this cell if it is empty.
	assign hit = tok_in.valid && !tok_in.found && occupied_q && (color_q == tok_in.rgb);
	assign ins = tok_in.valid && !tok_in.found && !occupied_q;

	always_comb begin
		tok_next = tok_in;
		if (hit || ins) begin
			tok_next.found = 1'b1;
			tok_next.index = MY_INDEX;
		end
		if (ins) begin
			tok_next.is_new = 1'b1;
		end
		// Occupied cells form a prefix, so the last one seen gives the count.
		if (occupied_q || ins) begin
			tok_next.count = MY_COUNT;
		end
	end

	// Occupancy and the token handed on: occupancy is set on insertion and
	// dropped as the last pixel of an image passes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q <= 1'b0;
			tok_q      <= '0;
		end else if (advance) begin
			tok_q <= tok_next;
			if (tok_in.valid && tok_in.last) begin
				occupied_q <= 1'b0;
			end else if (ins) begin
				occupied_q <= 1'b1;
			end
		end
	end

	// Colour held by this cell.
	always_ff @(posedge clk) begin
		if (advance && ins) begin
			color_q <= tok_in.rgb;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

FILE: rtl/core/palette_builder_distinct_colors.sv
// Each pixel's token is registered once in each of the PALETTE_DEPTH match cells, in order.
// Throughput: one pixel per cycle; the whole cell chain advances together and
// holds only while a finished result waits on the output.
// Reset: arst_n empties the palette and drops all requests in flight; stored
// colours are not cleared and are ignored until rewritten.
`default_nettype none

module palette_builder_distinct_colors #(
	parameter int unsigned PALETTE_DEPTH = 256
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	pbd_stream_if.sink   pixel,
	pbd_stream_if.source result
);

	import pbd_pkg::*;

	token_t chain [0:PALETTE_DEPTH];
	logic   advance;
	token_t tail;

	// The chain moves when its tail is empty or being taken.
	assign advance     = !chain[PALETTE_DEPTH].valid || result.ready;
	assign pixel.ready = advance;

	// Fresh token entering the first cell.
	always_comb begin
		chain[0].valid  = pixel.valid;
		chain[0].rgb    = pixel.payload.pixel_rgb;
		chain[0].last   = pixel.payload.last_pixel;
		chain[0].found  = 1'b0;
		chain[0].is_new = 1'b0;
		chain[0].index  = '0;
		chain[0].count  = '0;
	end

	// Row of match cells, one per palette entry.
	for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
		pbd_cell #(
			.CELL_INDEX (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.tok_in  (chain[k]),
			.tok_out (chain[k+1])
		);
	end

	// A token that found no cell is an overflow and reports index zero.
	assign tail                          = chain[PALETTE_DEPTH];
	assign result.valid                  = tail.valid;
	assign result.payload.palette_index  = tail.found ? tail.index : '0;
	assign result.payload.new_color      = tail.is_new;
	assign result.payload.overflow       = !tail.found;
	assign result.payload.color_count    = tail.count;
	assign result.payload.end_of_image   = tail.last;

	// An overflow never claims an entry and always reports index zero.
	a_overflow_index: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.payload.overflow |->
			!result.payload.new_color && (result.payload.palette_index == '0))
		else $error("overflow result carries an index or a new colour");

	// A stalled result keeps its contents while the chain is frozen.
	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(tail))
		else $error("result changed while stalled");

	// No input is taken while the chain is frozen.
	a_no_take_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !pixel.ready)
		else $error("pixel accepted while the chain is frozen");

endmodule

`default_nettype wire

FILE: dv/pbd_checker.sv
module pbd_checker #(
	parameter int unsigned PALETTE_DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pixel_valid,
	input  logic             pixel_ready,
	input  pbd_pkg::pixel_t  pixel_req,
	input  logic             result_valid,
	input  logic             result_ready,
	input  pbd_pkg::result_t result_req,
	output int               fail_count,
	output int               results_pending
);

	import pbd_pkg::*;

	// Our own copy of the palette: stored colours and how many are live.
	logic [RGB_W-1:0] palette_colours [PALETTE_DEPTH];
	int unsigned      palette_fill;

	// Expected results, oldest first.
	result_t pending_palette_results [$];

	initial begin
		fail_count      = 0;
		results_pending = 0;
		palette_fill    = 0;
	end

	// Look the colour up, store it if it is new and there is room, and clear
	// the table once the last pixel of an image has been handled.
	function automatic result_t predict_palette(pixel_t px);
		result_t     r;
		logic        hit;
		int unsigned k;
		r   = '0;
		hit = 1'b0;
		for (k = 0; k < palette_fill; k++) begin
			if (!hit && palette_colours[k] == px.pixel_rgb) begin
				hit             = 1'b1;
				r.palette_index = INDEX_W'(k);
			end
		end
		if (!hit) begin
			if (palette_fill < PALETTE_DEPTH) begin
				palette_colours[palette_fill] = px.pixel_rgb;
				r.palette_index               = INDEX_W'(palette_fill);
				r.new_color                   = 1'b1;
				palette_fill++;
			end else begin
				r.overflow = 1'b1;
			end
		end
		r.color_count  = COUNT_W'(palette_fill);
		r.end_of_image = px.last_pixel;
		if (px.last_pixel)
			palette_fill = 0;
		return r;
	endfunction

	function automatic void check_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			fail_count++;
		end
	endfunction

	// Predict on every accepted pixel and compare every accepted result.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (pixel_valid && pixel_ready)
				pending_palette_results.push_back(predict_palette(pixel_req));
			if (result_valid && result_ready) begin
				if (pending_palette_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual index %0d count %0d",
						$time, result_req.palette_index, result_req.color_count);
					fail_count++;
				end else begin
					want = pending_palette_results.pop_front();
					check_field("palette_index", want.palette_index, result_req.palette_index);
					check_field("new_color", want.new_color, result_req.new_color);
					check_field("overflow", want.overflow, result_req.overflow);
					check_field("color_count", want.color_count, result_req.color_count);
					check_field("end_of_image", want.end_of_image, result_req.end_of_image);
				end
			end
			results_pending <= pending_palette_results.size();
		end
	end

endmodule

FILE: dv/testbench.sv
module testbench;

	import pbd_pkg::*;

	localparam int unsigned PALETTE_DEPTH = 256;
	localparam int unsigned PIXEL_TARGET  = 600;
	localparam int unsigned HOLD_CYCLES   = 700;

	typedef enum {RX_FLOWING, RX_CHOPPY, RX_SPARSE} rx_mode_e;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   results_pending;
	int   pixels_sent;
	int   burst_left;
	bit   hold_off_request;

	pbd_stream_if #(.payload_t(pixel_t))  pixel_ch ();
	pbd_stream_if #(.payload_t(result_t)) result_ch ();

	palette_builder_distinct_colors #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.pixel (pixel_ch),
		.result(result_ch)
	);

	pbd_checker #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.pixel_valid    (pixel_ch.valid),
		.pixel_ready    (pixel_ch.ready),
		.pixel_req      (pixel_ch.payload),
		.result_valid   (result_ch.valid),
		.result_ready   (result_ch.ready),
		.result_req     (result_ch.payload),
		.fail_count     (fail_count),
		.results_pending(results_pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Safety net against a hung block.
	initial begin
		#2000000;
		$display("palette_builder_distinct_colors test failed");
		$finish;
	end

	// Offer one pixel request and hold it until taken; bursts end in a gap.
	task automatic send_pixel(input logic [RGB_W-1:0] rgb, input logic last);
		pixel_ch.valid   <= 1'b1;
		pixel_ch.payload <= '{pixel_rgb: rgb, last_pixel: last};
		@(posedge clk);
		while (!pixel_ch.ready) @(posedge clk);
		pixels_sent++;
		if (burst_left == 0) begin
			pixel_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end else begin
			burst_left--;
		end
	endtask

	// Stop offering and wait until every pixel has its result back.
	task automatic drain_results();
		pixel_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0) @(posedge clk);
	endtask

	// Receiver: random stall patterns, plus one long hold-off on request.
	initial begin
		rx_mode_e    mode;
		int unsigned stretch;
		result_ch.ready <= 1'b0;
		forever begin
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				@(posedge clk);
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end
			mode    = rx_mode_e'($urandom_range(0, 2));
			stretch = $urandom_range(5, 60);
			repeat (stretch) begin
				@(posedge clk);
				case (mode)
					RX_FLOWING: result_ch.ready <= 1'b1;
					RX_CHOPPY:  result_ch.ready <= 1'($urandom_range(0, 1));
					default:    result_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Stimulus: reset, directed pixels, then random images.
	initial begin
		logic [RGB_W-1:0] image_colours [PALETTE_DEPTH];
		logic [RGB_W-1:0] colour_pool [16];
		int unsigned      image_len;
		int unsigned      pool_len;
		int unsigned      j;
		bit               big_image;
		bit               first_big;
		logic             ends_image;
		logic [RGB_W-1:0] rgb;

		pixels_sent      = 0;
		burst_left       = 0;
		hold_off_request = 1'b0;
		first_big        = 1'b1;
		arst_n           <= 1'b0;
		pixel_ch.valid   <= 1'b0;
		pixel_ch.payload <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes, repeats of stored colours, and images of one pixel.
		send_pixel(24'h000000, 1'b0);
		send_pixel(24'hFFFFFF, 1'b0);
		send_pixel(24'h000000, 1'b0);
		send_pixel(24'hFF0000, 1'b0);
		send_pixel(24'h00FF00, 1'b0);
		send_pixel(24'h0000FF, 1'b0);
		send_pixel(24'hFFFFFF, 1'b0);
		send_pixel(24'hAAAAAA, 1'b0);
		send_pixel(24'h555555, 1'b0);
		send_pixel(24'h555555, 1'b1);
		send_pixel(24'h555555, 1'b1);
		send_pixel(24'hFFFFFF, 1'b1);
		send_pixel(24'h123456, 1'b0);
		send_pixel(24'h123456, 1'b0);
		send_pixel(24'hEDCBA9, 1'b1);
		drain_results();

		// Random images. The first large one fills the table exactly, then
		// mixes repeats of stored colours with unseen colours that overflow.
		while (pixels_sent < PIXEL_TARGET) begin
			big_image = first_big || ($urandom_range(0, 9) == 0);
			if (big_image) begin
				if (first_big)
					hold_off_request = 1'b1;
				image_len = $urandom_range(PALETTE_DEPTH + 2, PALETTE_DEPTH + 40);
				for (j = 0; j < image_len; j++) begin
					if (j < PALETTE_DEPTH) begin
						rgb = first_big ? {16'($urandom), 8'(j)} : 24'($urandom);
						image_colours[j] = rgb;
					end else if ($urandom_range(0, 1) == 0) begin
						rgb = image_colours[$urandom_range(0, PALETTE_DEPTH - 1)];
					end else begin
						rgb = 24'($urandom);
					end
					send_pixel(rgb, j == image_len - 1);
				end
				first_big = 1'b0;
			end else begin
				// Small image drawn from a small pool, so most pixels hit.
				pool_len  = $urandom_range(1, 12);
				image_len = $urandom_range(1, 40);
				for (j = 0; j < pool_len; j++)
					colour_pool[j] = 24'($urandom);
				for (j = 0; j < image_len; j++) begin
					rgb = ($urandom_range(0, 9) == 0) ? 24'($urandom)
						: colour_pool[$urandom_range(0, pool_len - 1)];
					// Now and then the last-pixel mark is missing, so the
					// table runs on into the next image.
					ends_image = (j == image_len - 1) && ($urandom_range(0, 7) != 0);
					send_pixel(rgb, ends_image);
				end
			end
			if ($urandom_range(0, 5) == 0)
				drain_results();
		end

		drain_results();
		repeat (PALETTE_DEPTH + 50) @(posedge clk);
		if (fail_count == 0 && results_pending == 0) begin
			$display("palette_builder_distinct_colors test passed");
		end else begin
			$display("palette_builder_distinct_colors test failed");
		end
		$finish;
	end

endmodule
